// ===== rtl/core/gcpf_pkg.sv =====
// Shared types and constants of the collision grid pair finder.
package gcpf_pkg;

    localparam int GRID_DIM_DEF   = 16;
    localparam int CELL_SLOTS_DEF = 4;
    localparam int ID_BITS_DEF    = 16;

    localparam int INV_W   = 24;
    localparam int POS_W   = 32;
    localparam int OID_W   = 16;
    localparam int SLOT_W  = 14;
    localparam int CRD_W   = 4;
    localparam int OFS_W   = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [INV_W-1:0] INV_RESET = 24'd65536;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_PAIR     = 2'd2,
        ST_CLEARED  = 2'd3
    } status_t;

    localparam logic [PADDR_W-1:0] ADDR_INV_CELL_SIZE = 3'd0;

endpackage

// ===== rtl/core/gcpf_regs.sv =====
// Configuration register file on the APB-style port.
module gcpf_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcpf_pkg::PADDR_W-1:0]  paddr,
    input  logic [gcpf_pkg::PDATA_W-1:0]  pwdata,
    output logic [gcpf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [gcpf_pkg::INV_W-1:0]    inv_cell_size
);
    import gcpf_pkg::*;

    logic [INV_W-1:0] inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= INV_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_INV_CELL_SIZE)
        begin
            inv_reg <= pwdata[INV_W-1:0];
        end
    end

    assign pready        = 1'b1;
    assign inv_cell_size = inv_reg;
    assign prdata        = (paddr == ADDR_INV_CELL_SIZE) ? PDATA_W'(inv_reg) : '0;

endmodule

// ===== rtl/core/gcpf_store.sv =====
// Slot store: single-port synchronous memory of valid bit and id per slot.
module gcpf_store
#(
    parameter int DEPTH   = 16384,
    parameter int ID_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   addr,
    input  logic [ID_BITS:0]           wdata,
    output logic [ID_BITS:0]           rdata
);
    logic [ID_BITS:0] mem [DEPTH];
    logic [ID_BITS:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/grid_collision_pair_finder_core.sv =====
// Top level of the uniform-grid collision pair finder.
// Usage:
//   Input channel (in_valid/in_ready) takes one request word: insert, pair query or
//   clear. Output channel (out_valid/out_ready) returns result words in order.
//   Insert: occupied slots are probed in turn until a free one takes the object;
//   the position mapping shares one multiplier over the three axes.
//   A full store gives a store-full word without probing.
//   Query: each cell list is read slot by slot, then one pair word per cycle while the
//   receiver keeps up, up to CELL_SLOTS^2 words, the last one flagged.
//   Clear: sweeps every slot, then one cleared word.
//   Reset runs the same sweep with no word emitted;
//   in_ready stays low until it ends. Configuration writes are taken at any time.
//   One request is worked at a time; the memory port sets the pace. A result word
//   waits in an output register while the next request is accepted; a stalled
//   receiver holds the block at its next result.
module grid_collision_pair_finder_core
#(
    parameter int GRID_DIM   = gcpf_pkg::GRID_DIM_DEF,
    parameter int CELL_SLOTS = gcpf_pkg::CELL_SLOTS_DEF,
    parameter int ID_BITS    = gcpf_pkg::ID_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcpf_pkg::PADDR_W-1:0]  paddr,
    input  logic [gcpf_pkg::PDATA_W-1:0]  pwdata,
    output logic [gcpf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic signed [gcpf_pkg::POS_W-1:0] pos_x,
    input  logic signed [gcpf_pkg::POS_W-1:0] pos_y,
    input  logic signed [gcpf_pkg::POS_W-1:0] pos_z,
    input  logic [gcpf_pkg::OID_W-1:0]    object_id,
    input  logic                          batch_last,
    input  logic [gcpf_pkg::CRD_W-1:0]    cell_x,
    input  logic [gcpf_pkg::CRD_W-1:0]    cell_y,
    input  logic [gcpf_pkg::CRD_W-1:0]    cell_z,
    input  logic signed [gcpf_pkg::OFS_W-1:0] offset_dx,
    input  logic signed [gcpf_pkg::OFS_W-1:0] offset_dy,
    input  logic signed [gcpf_pkg::OFS_W-1:0] offset_dz,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [gcpf_pkg::SLOT_W-1:0]   slot_index,
    output logic [gcpf_pkg::OID_W-1:0]    first_id,
    output logic [gcpf_pkg::OID_W-1:0]    second_id,
    output logic                          last
);
    import gcpf_pkg::*;

    localparam int DEPTH = GRID_DIM * GRID_DIM * GRID_DIM * CELL_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GRID_DIM);
    localparam int NW    = $clog2(CELL_SLOTS + 1);
    localparam int IW    = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
    localparam int PW    = POS_W + INV_W + 1;
    localparam int SW    = PW + 1;
    localparam logic signed [SW-1:0] HALF_GRID = SW'(GRID_DIM / 2) <<< 32;
    localparam logic [AW:0] DEPTH_CNT = (AW+1)'(DEPTH);

    typedef enum logic [12:0] {
        S_CLR  = 13'b0000000000001,
        S_IDLE = 13'b0000000000010,
        S_MUL  = 13'b0000000000100,
        S_CELL = 13'b0000000001000,
        S_BASE = 13'b0000000010000,
        S_PRD  = 13'b0000000100000,
        S_PCHK = 13'b0000001000000,
        S_HRD  = 13'b0000010000000,
        S_HCHK = 13'b0000100000000,
        S_NRD  = 13'b0001000000000,
        S_NCHK = 13'b0010000000000,
        S_PAIR = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [INV_W-1:0] inv_cell_size;

    gcpf_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .inv_cell_size (inv_cell_size)
    );

    logic            mem_rd, mem_wr;
    logic [AW-1:0]   mem_addr;
    logic [ID_BITS:0] mem_wdata, mem_rdata;

    gcpf_store #(.DEPTH(DEPTH), .ID_BITS(ID_BITS)) u_store
    (
        .clk   (clk),
        .rd_en (mem_rd),
        .wr_en (mem_wr),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // request registers
    req_t                    req_reg;
    logic signed [POS_W-1:0] pos_reg [3];
    logic [ID_BITS-1:0]      id_reg;
    logic                    bl_reg;
    logic [CRD_W-1:0]        qc_reg [3];
    logic [OFS_W-1:0]        qo_reg [3];

    // working registers
    logic [1:0]              axis_reg;
    logic signed [PW-1:0]    prod_reg;
    logic [CW-1:0]           cell_reg [3];
    logic [AW-1:0]           probe_reg;
    logic [AW-1:0]           hbase_reg, nbase_reg;
    logic [AW-1:0]           clr_reg;
    logic                    clr_emit_reg;
    logic [AW:0]             fill_reg;
    logic [NW-1:0]           n_reg, nh_reg, nn_reg;
    logic [IW-1:0]           a_reg, b_reg;
    logic [ID_BITS-1:0]      hid_reg [CELL_SLOTS];
    logic [ID_BITS-1:0]      nid_reg [CELL_SLOTS];

    // output register
    logic                    out_valid_reg;
    logic [1:0]              status_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [OID_W-1:0]        first_reg, second_reg;
    logic                    last_reg;

    logic out_free;
    logic in_fire;
    logic [ID_BITS+OID_W-1:0] id_in_ext;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign id_in_ext = {{ID_BITS{1'b0}}, object_id};

    function automatic logic [AW-1:0] cell_base(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        return AW'(((32'(x) * 32'(GRID_DIM) + 32'(y)) * 32'(GRID_DIM) + 32'(z))
                   * 32'(CELL_SLOTS));
    endfunction

    function automatic logic [OID_W-1:0] id_out(input logic [ID_BITS-1:0] v);
        logic [ID_BITS+OID_W-1:0] e;
        e = {{OID_W{1'b0}}, v};
        return e[OID_W-1:0];
    endfunction

    // axis mapping from the registered product
    logic signed [SW-1:0] sum_w;
    logic [SW-33:0]       hi_w;
    logic [CW-1:0]        cell_w;

    always_comb
    begin
        sum_w = SW'(prod_reg) + HALF_GRID;
        hi_w  = sum_w[SW-1:32];
        if (sum_w < 0)
        begin
            cell_w = '0;
        end
        else if (hi_w > (SW-32)'(GRID_DIM - 1))
        begin
            cell_w = CW'(GRID_DIM - 1);
        end
        else
        begin
            cell_w = hi_w[CW-1:0];
        end
    end

    // query coordinates
    logic signed [7:0] hq_w [3];
    logic signed [7:0] nq_w [3];
    logic              hok_w, nok_w;

    always_comb
    begin
        hok_w = 1'b1;
        nok_w = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            hq_w[i] = 8'(qc_reg[i]);
            nq_w[i] = hq_w[i] + 8'($signed(qo_reg[i]));
            if (hq_w[i] >= 8'(GRID_DIM))
            begin
                hok_w = 1'b0;
            end
            if (nq_w[i] < 0 || nq_w[i] >= 8'(GRID_DIM))
            begin
                nok_w = 1'b0;
            end
        end
    end

    logic slot_free_w;
    logic pair_last_w;
    assign slot_free_w = !mem_rdata[ID_BITS];
    assign pair_last_w = (NW'(a_reg) == nh_reg - 1'b1) && (NW'(b_reg) == nn_reg - 1'b1);

    // memory port
    always_comb
    begin
        mem_rd    = 1'b0;
        mem_wr    = 1'b0;
        mem_addr  = probe_reg;
        mem_wdata = {1'b1, id_reg};
        unique case (state_reg)
            S_CLR:
            begin
                mem_wr    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
            end
            S_PRD:
            begin
                mem_rd = 1'b1;
            end
            S_PCHK:
            begin
                mem_wr = slot_free_w && out_free;
            end
            S_HRD:
            begin
                mem_rd   = 1'b1;
                mem_addr = hbase_reg + AW'(n_reg);
            end
            S_NRD:
            begin
                mem_rd   = 1'b1;
                mem_addr = nbase_reg + AW'(n_reg);
            end
            default:
            begin
                mem_rd = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = clr_emit_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    priority case (req_type)
                        REQ_INSERT: state_next = S_MUL;
                        REQ_QUERY:  state_next = S_BASE;
                        REQ_CLEAR:  state_next = S_CLR;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL:  state_next = S_CELL;
            S_CELL: state_next = (axis_reg == 2'd2) ? S_BASE : S_MUL;
            S_BASE:
            begin
                if (req_reg == REQ_INSERT)
                begin
                    state_next = (fill_reg == DEPTH_CNT) ? S_DONE : S_PRD;
                end
                else
                begin
                    state_next = (hok_w && nok_w) ? S_HRD : S_IDLE;
                end
            end
            S_PRD:  state_next = S_PCHK;
            S_PCHK:
            begin
                if (!slot_free_w)
                begin
                    state_next = S_PRD;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_HRD:  state_next = S_HCHK;
            S_HCHK:
            begin
                if (slot_free_w)
                begin
                    state_next = (n_reg == '0) ? S_IDLE : S_NRD;
                end
                else if (n_reg == NW'(CELL_SLOTS - 1))
                begin
                    state_next = S_NRD;
                end
                else
                begin
                    state_next = S_HRD;
                end
            end
            S_NRD:  state_next = S_NCHK;
            S_NCHK:
            begin
                if (slot_free_w)
                begin
                    state_next = (n_reg == '0) ? S_IDLE : S_PAIR;
                end
                else if (n_reg == NW'(CELL_SLOTS - 1))
                begin
                    state_next = S_PAIR;
                end
                else
                begin
                    state_next = S_NRD;
                end
            end
            S_PAIR:
            begin
                if (out_free && pair_last_w)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            clr_emit_reg  <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            axis_reg      <= '0;
            n_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg  <= (clr_reg == AW'(DEPTH - 1)) ? '0 : clr_reg + 1'b1;
                    fill_reg <= '0;
                end
                S_IDLE:
                begin
                    axis_reg     <= '0;
                    n_reg        <= '0;
                    clr_reg      <= '0;
                    clr_emit_reg <= 1'b1;
                end
                S_CELL:
                begin
                    axis_reg <= axis_reg + 1'b1;
                end
                S_PCHK:
                begin
                    if (slot_free_w && out_free)
                    begin
                        fill_reg      <= fill_reg + 1'b1;
                        out_valid_reg <= 1'b1;
                    end
                end
                S_HCHK:
                begin
                    if (slot_free_w || n_reg == NW'(CELL_SLOTS - 1))
                    begin
                        nh_reg <= slot_free_w ? n_reg : n_reg + 1'b1;
                        n_reg  <= '0;
                    end
                    else
                    begin
                        n_reg <= n_reg + 1'b1;
                    end
                end
                S_NCHK:
                begin
                    a_reg <= '0;
                    b_reg <= '0;
                    if (slot_free_w || n_reg == NW'(CELL_SLOTS - 1))
                    begin
                        nn_reg <= slot_free_w ? n_reg : n_reg + 1'b1;
                        n_reg  <= '0;
                    end
                    else
                    begin
                        n_reg <= n_reg + 1'b1;
                    end
                end
                S_PAIR:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (NW'(b_reg) == nn_reg - 1'b1)
                        begin
                            b_reg <= '0;
                            a_reg <= a_reg + 1'b1;
                        end
                        else
                        begin
                            b_reg <= b_reg + 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    clr_emit_reg <= clr_emit_reg;
                end
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg   <= req_t'(req_type);
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            id_reg    <= id_in_ext[ID_BITS-1:0];
            bl_reg    <= batch_last;
            qc_reg[0] <= cell_x;
            qc_reg[1] <= cell_y;
            qc_reg[2] <= cell_z;
            qo_reg[0] <= offset_dx;
            qo_reg[1] <= offset_dy;
            qo_reg[2] <= offset_dz;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PW'(pos_reg[axis_reg] * $signed({1'b0, inv_cell_size}));
        end
        if (state_reg == S_CELL)
        begin
            cell_reg[axis_reg] <= cell_w;
        end
        if (state_reg == S_BASE)
        begin
            probe_reg <= cell_base(cell_reg[0], cell_reg[1], cell_reg[2]);
            hbase_reg <= cell_base(hq_w[0][CW-1:0], hq_w[1][CW-1:0], hq_w[2][CW-1:0]);
            nbase_reg <= cell_base(nq_w[0][CW-1:0], nq_w[1][CW-1:0], nq_w[2][CW-1:0]);
        end
        if (state_reg == S_PCHK && !slot_free_w)
        begin
            probe_reg <= (probe_reg == AW'(DEPTH - 1)) ? '0 : probe_reg + 1'b1;
        end
        if (state_reg == S_HCHK && !slot_free_w)
        begin
            hid_reg[n_reg[IW-1:0]] <= mem_rdata[ID_BITS-1:0];
        end
        if (state_reg == S_NCHK && !slot_free_w)
        begin
            nid_reg[n_reg[IW-1:0]] <= mem_rdata[ID_BITS-1:0];
        end
        if (out_free)
        begin
            if (state_reg == S_PCHK && slot_free_w)
            begin
                status_reg <= ST_INSERTED;
                slot_reg   <= SLOT_W'(probe_reg);
                first_reg  <= id_out(id_reg);
                second_reg <= '0;
                last_reg   <= bl_reg;
            end
            if (state_reg == S_PAIR)
            begin
                status_reg <= ST_PAIR;
                slot_reg   <= '0;
                first_reg  <= id_out(hid_reg[a_reg]);
                second_reg <= id_out(nid_reg[b_reg]);
                last_reg   <= pair_last_w;
            end
            if (state_reg == S_DONE)
            begin
                slot_reg   <= '0;
                second_reg <= '0;
                if (req_reg == REQ_CLEAR)
                begin
                    status_reg <= ST_CLEARED;
                    first_reg  <= '0;
                    last_reg   <= 1'b1;
                end
                else
                begin
                    status_reg <= ST_FULL;
                    first_reg  <= id_out(id_reg);
                    last_reg   <= bl_reg;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_index = slot_reg;
    assign first_id   = first_reg;
    assign second_id  = second_reg;
    assign last       = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_CNT)
        else $error("slot fill count beyond store depth");

    a_clear_enters_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && req_type == REQ_CLEAR |=> state_reg == S_CLR)
        else $error("clear request did not start the sweep");

    a_no_write_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PCHK && !out_free |-> !mem_wr)
        else $error("slot written while result register is blocked");

    a_result_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(first_reg))
        else $error("pending result overwritten");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the collision grid pair finder: directed table, random requests, scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import gcpf_pkg::*;

    localparam int GD = GRID_DIM_DEF;
    localparam int CS = CELL_SLOTS_DEF;
    localparam int DEPTH = GD * GD * GD * CS;

    typedef struct packed {
        logic [1:0]        req;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [POS_W-1:0]  pz;
        logic [OID_W-1:0]  oid;
        logic              bl;
        logic [CRD_W-1:0]  cx;
        logic [CRD_W-1:0]  cy;
        logic [CRD_W-1:0]  cz;
        logic [OFS_W-1:0]  dx;
        logic [OFS_W-1:0]  dy;
        logic [OFS_W-1:0]  dz;
    } request_t;

    typedef struct packed {
        logic [1:0]        st;
        logic [SLOT_W-1:0] slot;
        logic [OID_W-1:0]  a;
        logic [OID_W-1:0]  b;
        logic              lst;
    } word_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_ready;
    logic [1:0] req_type;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic [OID_W-1:0] object_id;
    logic batch_last;
    logic [CRD_W-1:0] cell_x, cell_y, cell_z;
    logic signed [OFS_W-1:0] offset_dx, offset_dy, offset_dz;
    logic out_valid, out_ready;
    logic [1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [OID_W-1:0] first_id, second_id;
    logic last;

    grid_collision_pair_finder_core dut (.*);

    logic [INV_W-1:0] model_inv;
    bit               slot_used [DEPTH];
    logic [OID_W-1:0] slot_ids  [DEPTH];
    int               used_count;
    word_t            expected_words [$];
    int               errors;
    bit               in_calm, out_calm;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [3:0] axis_cell(logic [POS_W-1:0] raw);
        logic signed [63:0] s;
        logic [63:0] c;
        s = $signed({{32{raw[31]}}, raw}) * $signed({40'd0, model_inv})
            + (64'(GD / 2) << 32);
        if (s < 0)
            return 4'd0;
        c = 64'(s) >> 32;
        if (c > 64'(GD - 1))
            c = 64'(GD - 1);
        return c[3:0];
    endfunction

    function automatic int cell_list(int x, int y, int z, ref logic [OID_W-1:0] ids [CS]);
        int base;
        int n;
        n = 0;
        if (x < 0 || y < 0 || z < 0 || x >= GD || y >= GD || z >= GD)
            return 0;
        base = (z + y * GD + x * GD * GD) * CS;
        while (n < CS && slot_used[base + n]) begin
            ids[n] = slot_ids[base + n];
            n++;
        end
        return n;
    endfunction

    task automatic predict_words(request_t r);
        int idx, nh, no;
        logic [OID_W-1:0] home [CS];
        logic [OID_W-1:0] other [CS];
        word_t w;
        w = '0;
        case (r.req)
            REQ_INSERT:
            begin
                idx = (axis_cell(r.pz) + axis_cell(r.py) * GD + axis_cell(r.px) * GD * GD) * CS;
                w.a = r.oid;
                w.lst = r.bl;
                if (used_count == DEPTH)
                    w.st = ST_FULL;
                else
                begin
                    while (slot_used[idx])
                        idx = (idx + 1) % DEPTH;
                    slot_used[idx] = 1'b1;
                    slot_ids[idx] = r.oid;
                    used_count++;
                    w.st = ST_INSERTED;
                    w.slot = idx[SLOT_W-1:0];
                end
                expected_words.push_back(w);
            end
            REQ_QUERY:
            begin
                nh = cell_list(r.cx, r.cy, r.cz, home);
                no = cell_list(int'(r.cx) + int'($signed(r.dx)), int'(r.cy) + int'($signed(r.dy)),
                               int'(r.cz) + int'($signed(r.dz)), other);
                if (nh != 0 && no != 0)
                    for (int i = 0; i < nh; i++)
                        for (int j = 0; j < no; j++)
                        begin
                            w.st = ST_PAIR;
                            w.a = home[i];
                            w.b = other[j];
                            w.lst = (i == nh - 1 && j == no - 1);
                            expected_words.push_back(w);
                        end
            end
            REQ_CLEAR:
            begin
                foreach (slot_used[k])
                    slot_used[k] = 1'b0;
                used_count = 0;
                w.st = ST_CLEARED;
                w.lst = 1'b1;
                expected_words.push_back(w);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word st=%0d", $time, status);
                errors++;
            end
            else
            begin
                word_t e;
                e = expected_words.pop_front();
                if (e !== {status, slot_index, first_id, second_id, last})
                begin
                    $display("%0t: mismatch expected st=%0d slot=%0d a=%0d b=%0d last=%0b",
                             $time, e.st, e.slot, e.a, e.b, e.lst);
                    $display("%0t:            actual st=%0d slot=%0d a=%0d b=%0d last=%0b",
                             $time, status, slot_index, first_id, second_id, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
        out_ready <= out_calm ? 1'b1 : ($urandom_range(99) >= 29);

    task automatic write_inv(logic [INV_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_INV_CELL_SIZE;
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_inv = value;
    endtask

    task automatic send(request_t r);
        while (!in_calm && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {req_type, pos_x, pos_y, pos_z, object_id, batch_last,
         cell_x, cell_y, cell_z, offset_dx, offset_dy, offset_dz} <= r;
        do
            @(posedge clk);
        while (!in_ready);
        predict_words(r);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_words.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40)
            @(posedge clk);
    endtask

    function automatic request_t rand_req();
        logic [159:0] bits;
        bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return bits[$bits(request_t)-1:0];
    endfunction

    function automatic request_t ins(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                     logic [15:0] id, logic b);
        request_t r;
        r = '0;
        r.req = REQ_INSERT;
        r.px = x;
        r.py = y;
        r.pz = z;
        r.oid = id;
        r.bl = b;
        return r;
    endfunction

    function automatic request_t qry(int x, int y, int z, logic [1:0] ox, logic [1:0] oy,
                                     logic [1:0] oz);
        request_t r;
        r = rand_req();
        r.req = REQ_QUERY;
        r.cx = CRD_W'(x);
        r.cy = CRD_W'(y);
        r.cz = CRD_W'(z);
        r.dx = ox;
        r.dy = oy;
        r.dz = oz;
        return r;
    endfunction

    function automatic request_t rand_pos_insert();
        logic [31:0] c [3];
        request_t r;
        foreach (c[k])
            c[k] = $urandom_range(3) == 0 ? $urandom()
                   : 32'($signed($urandom_range(6)) - 3) <<< 16 | 32'($urandom_range(65535));
        r = ins(c[0], c[1], c[2], 16'($urandom()), 1'($urandom()));
        return r;
    endfunction

    request_t table_rows [$];
    word_t    table_words [$];
    bit       table_known [$];

    task automatic add_row(request_t r, bit known, word_t w);
        table_rows.push_back(r);
        table_known.push_back(known);
        table_words.push_back(w);
    endtask

    initial begin
        request_t r;
        word_t w;
        errors = 0;
        model_inv = INV_RESET;
        used_count = 0;
        foreach (slot_used[k])
            slot_used[k] = 1'b0;
        in_calm = 1'b0;
        out_calm = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        {req_type, pos_x, pos_y, pos_z, object_id, batch_last,
         cell_x, cell_y, cell_z, offset_dx, offset_dy, offset_dz} = '0;
        out_ready = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed table: extremes, every request, empty/outside/self queries
        add_row(ins(0, 0, 0, 16'h1234, 1'b1), 1,
                '{ST_INSERTED, 14'((8 + 8 * GD + 8 * GD * GD) * CS), 16'h1234, 16'd0, 1'b1});
        add_row(ins(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1'b0), 1,
                '{ST_INSERTED, 14'(DEPTH - CS), 16'hFFFF, 16'd0, 1'b0});
        add_row(ins(32'h80000000, 32'h80000000, 32'h80000000, 16'h0000, 1'b1), 1,
                '{ST_INSERTED, 14'd0, 16'h0000, 16'd0, 1'b1});
        for (int k = 0; k < 5; k++)
            add_row(ins(0, 0, 0, 16'(16'hA0 + k), k[0]), 0, '0);
        add_row(ins(32'h00010000, 0, 0, 16'h0BEE, 1'b0), 0, '0);
        add_row(ins(32'hFFFF0000, 32'hFFFF8000, 0, 16'h0C0C, 1'b1), 0, '0);
        add_row(qry(8, 8, 8, 2'b00, 2'b00, 2'b00), 0, '0);
        add_row(qry(8, 8, 8, 2'b01, 2'b00, 2'b00), 0, '0);
        add_row(qry(8, 8, 9, 2'b11, 2'b00, 2'b11), 0, '0);
        add_row(qry(1, 1, 1, 2'b10, 2'b10, 2'b10), 0, '0);
        add_row(qry(14, 14, 14, 2'b01, 2'b01, 2'b01), 0, '0);
        add_row(qry(15, 15, 15, 2'b00, 2'b00, 2'b00), 0, '0);
        add_row(qry(0, 0, 0, 2'b00, 2'b00, 2'b00), 0, '0);
        add_row(qry(3, 4, 5, 2'b01, 2'b11, 2'b00), 0, '0);
        r = rand_req();
        r.req = REQ_NONE;
        add_row(r, 0, '0);
        r = rand_req();
        r.req = REQ_CLEAR;
        add_row(r, 1, '{ST_CLEARED, 14'd0, 16'd0, 16'd0, 1'b1});
        add_row(qry(8, 8, 8, 2'b00, 2'b00, 2'b00), 0, '0);

        foreach (table_rows[i])
        begin
            send(table_rows[i]);
            if (table_known[i] && expected_words[$] !== table_words[i])
            begin
                $display("%0t: row %0d expected %h, table %h", $time, i,
                         expected_words[$], table_words[i]);
                errors++;
            end
        end
        drain();

        // settings sweep: zero, smallest, largest, 0x004000 (calm handshakes), reset value, random
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_inv(24'd0);
                1: write_inv(24'd1);
                2: write_inv(24'hFFFFFF);
                3: write_inv(24'h004000);
                4: write_inv(INV_RESET);
                default: write_inv(24'($urandom_range(24'h030000, 24'h004000)));
            endcase
            in_calm = (phase == 3);
            out_calm = (phase == 3);
            for (int n = 0; n < 40; n++)
            begin
                int pick;
                pick = $urandom_range(99);
                if (pick < 55)
                    r = rand_pos_insert();
                else if (pick < 95)
                    r = qry($urandom_range(14), $urandom_range(14), $urandom_range(14),
                            2'($urandom()), 2'($urandom()), 2'($urandom()));
                else if (pick < 98)
                begin
                    r = rand_req();
                    r.req = REQ_CLEAR;
                end
                else
                begin
                    r = rand_req();
                    r.req = REQ_NONE;
                end
                if (r.req == REQ_QUERY && $urandom_range(1))
                begin
                    r.cx = CRD_W'($urandom_range(9, 7));
                    r.cy = CRD_W'($urandom_range(9, 7));
                    r.cz = CRD_W'($urandom_range(9, 7));
                end
                send(r);
                if (n == 20)
                    drain();
            end
            drain();
        end

        in_calm = 1'b0;
        out_calm = 1'b0;
        drain();
        if (errors == 0 && expected_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
